[design/ccs_pkg.sv]
package ccs_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned TBL_AW = 15;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;

  localparam int unsigned FIFO_AW = 3;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [7:0] QMARK = 8'h3F;

  // register index, taken from paddr[2]
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic [1:0] DIR_B5_TO_GBK = 2'd0;
  localparam logic [1:0] DIR_GBK_TO_B5 = 2'd1;
  localparam logic [1:0] DIR_B5_TO_UNI = 2'd2;
  localparam logic [1:0] DIR_GBK_TO_UNI = 2'd3;
  localparam logic [1:0] DIR_RESET = DIR_GBK_TO_UNI;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_TERM,
    KIND_QNUL,
    KIND_PAIR,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eot;
  } out_item_t;

  // lead byte in bits 7:0, trail in 15:8; row is lead & 0x7f
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CODE_W-1:0] code);
    tbl_addr = {code[6:0], code[15:8]};
  endfunction

endpackage

[design/chinese_charset_transcoder_unit.sv]
// Channel  Handshake                         Payload
// cfg      psel/penable/pwrite/pready (APB)  paddr, pwdata, prdata (direction)
// in       in_valid / in_ready               mode, in_byte, gbk_code, trad_code,
//                                            big5_code, unicode_code
// out      out_valid / out_ready             out_byte, last, end_of_text
//
// An item's first table read returns in the cycle after accept, and a dependent
// second read returns in the cycle after that; in_ready is low while an item
// sits in the first read stage. A lead byte alone only sets the pending state.
// After rst all five tables are cleared, one entry per cycle over all 32768 entries,
// with in_ready low; cfg writes are taken meanwhile.
// Results go through an 8-byte queue; in_ready drops when it lacks room.
module chinese_charset_transcoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  in_byte,
  input  logic [15:0] gbk_code,
  input  logic [15:0] trad_code,
  input  logic [15:0] big5_code,
  input  logic [15:0] unicode_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        end_of_text
);
  import ccs_pkg::*;

  localparam int unsigned FIFO_CW = FIFO_AW + 1;
  localparam logic [FIFO_CW-1:0] ROOM_IDLE = FIFO_CW'(FIFO_DEPTH - 2);
  localparam logic [FIFO_CW-1:0] ROOM_BUSY = FIFO_CW'(FIFO_DEPTH - 4);

  // tables
  logic [CODE_W-1:0] s2t_mem [TBL_DEPTH];
  logic [CODE_W-1:0] t2s_mem [TBL_DEPTH];
  logic [CODE_W-1:0] g2u_mem [TBL_DEPTH];
  logic [CODE_W-1:0] g2b_mem [TBL_DEPTH];
  logic [CODE_W-1:0] b2g_mem [TBL_DEPTH];

  logic [CODE_W-1:0] s2t_rd, t2s_rd, g2u_rd, g2b_rd, b2g_rd;
  logic [TBL_AW-1:0] g2u_ra;
  logic              s2t_we, t2s_we, g2u_we, g2b_we, b2g_we;
  logic [TBL_AW-1:0] s2t_wa, t2s_wa, g2u_wa, g2b_wa, b2g_wa;
  logic [CODE_W-1:0] s2t_wd, t2s_wd, g2u_wd, g2b_wd, b2g_wd;

  logic              clr_busy;
  logic [TBL_AW-1:0] clr_idx;

  logic [1:0] direction;
  logic       lead_pending;
  logic [7:0] lead_byte;

  // first read stage
  logic              s1_v;
  kind_t             s1_kind;
  logic [1:0]        s1_dir;
  logic [7:0]        s1_byte;
  logic [CODE_W-1:0] s1_pair, s1_g, s1_t, s1_b5, s1_u;

  // second read stage
  logic              s2_v;
  kind_t             s2_kind;
  logic [1:0]        s2_dir;
  logic [7:0]        s2_byte;
  logic [CODE_W-1:0] s2_code;

  // result queue
  out_item_t          fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic [FIFO_CW-1:0] cnt;

  logic              in_fire, cfg_wr, pop;
  logic              enters;
  kind_t             in_kind;
  logic [CODE_W-1:0] in_pair;
  logic [TBL_AW-1:0] rd1_addr, rd2_addr;
  logic [CODE_W-1:0] s1_code, gbk_sel, s2_result;
  logic              load_fire, g_ne_t, big5_ok;
  logic [1:0]        push_n;
  out_item_t         item0, item1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DIRECTION) ? {30'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_RESET;
    end else if (cfg_wr && paddr[2] == REG_DIRECTION) begin
      direction <= pwdata[1:0];
    end
  end

  // ---------------- accept ----------------
  assign in_ready = !clr_busy && !s1_v && (cnt <= (s2_v ? ROOM_BUSY : ROOM_IDLE));
  assign in_fire  = in_valid && in_ready;
  assign in_pair  = {in_byte, lead_byte};
  assign rd1_addr = mode ? tbl_addr(gbk_code) : tbl_addr(in_pair);
  // a lone lead byte only sets the pending state
  assign enters   = mode || lead_pending || !in_byte[7];

  always_comb begin
    if (mode) begin
      in_kind = KIND_LOAD;
    end else if (lead_pending) begin
      in_kind = (in_byte == 8'd0) ? KIND_QNUL : KIND_PAIR;
    end else if (in_byte == 8'd0) begin
      in_kind = KIND_TERM;
    end else begin
      in_kind = KIND_ASCII;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_byte    <= 8'd0;
    end else if (in_fire && !mode) begin
      if (lead_pending) begin
        lead_pending <= 1'b0;
      end else if (in_byte[7]) begin
        lead_pending <= 1'b1;
        lead_byte    <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_fire && enters;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind <= in_kind;
      s1_dir  <= direction;
      s1_byte <= in_byte;
      s1_pair <= in_pair;
      s1_g    <= gbk_code;
      s1_t    <= trad_code;
      s1_b5   <= big5_code;
      s1_u    <= unicode_code;
    end
  end

  // ---------------- first read data ----------------
  always_comb begin
    gbk_sel  = (s2t_rd == '0) ? s1_pair : s2t_rd;
    rd2_addr = '0;
    s1_code  = '0;
    case (s1_dir)
      DIR_B5_TO_GBK: begin
        rd2_addr = tbl_addr(b2g_rd);
        s1_code  = b2g_rd;
      end
      DIR_GBK_TO_B5: rd2_addr = tbl_addr(gbk_sel);
      DIR_B5_TO_UNI: rd2_addr = tbl_addr(b2g_rd);
      DIR_GBK_TO_UNI: s1_code = g2u_rd;
      default: ;
    endcase
  end

  assign load_fire = s1_v && (s1_kind == KIND_LOAD);
  assign g_ne_t    = (s1_g != s1_t);
  // simp_to_trad entry after this record's own write
  assign big5_ok   = g_ne_t ? (s1_t == '0) : (s2t_rd == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v && (s1_kind != KIND_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_kind <= s1_kind;
      s2_dir  <= s1_dir;
      s2_byte <= s1_byte;
      s2_code <= s1_code;
    end
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == TBL_AW'(TBL_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------- table ports ----------------
  always_comb begin
    if (clr_busy) begin
      {s2t_we, t2s_we, g2u_we, g2b_we, b2g_we} = 5'b11111;
      s2t_wa = clr_idx;
      t2s_wa = clr_idx;
      g2u_wa = clr_idx;
      g2b_wa = clr_idx;
      b2g_wa = clr_idx;
      s2t_wd = '0;
      t2s_wd = '0;
      g2u_wd = '0;
      g2b_wd = '0;
      b2g_wd = '0;
    end else begin
      s2t_we = load_fire && g_ne_t;
      t2s_we = load_fire && g_ne_t;
      g2u_we = load_fire;
      g2b_we = load_fire && big5_ok;
      b2g_we = load_fire && big5_ok;
      s2t_wa = tbl_addr(s1_g);
      t2s_wa = tbl_addr(s1_t);
      g2u_wa = tbl_addr(s1_g);
      g2b_wa = tbl_addr(s1_g);
      b2g_wa = tbl_addr(s1_b5);
      s2t_wd = s1_t;
      t2s_wd = s1_g;
      g2u_wd = s1_u;
      g2b_wd = s1_b5;
      b2g_wd = s1_g;
    end
  end

  // gbk_to_unicode serves both the first read and the second
  assign g2u_ra = s1_v ? rd2_addr : rd1_addr;

  always_ff @(posedge clk) begin
    if (s2t_we) begin
      s2t_mem[s2t_wa] <= s2t_wd;
    end
    s2t_rd <= s2t_mem[rd1_addr];
  end

  always_ff @(posedge clk) begin
    if (t2s_we) begin
      t2s_mem[t2s_wa] <= t2s_wd;
    end
    t2s_rd <= t2s_mem[rd2_addr];
  end

  always_ff @(posedge clk) begin
    if (g2u_we) begin
      g2u_mem[g2u_wa] <= g2u_wd;
    end
    g2u_rd <= g2u_mem[g2u_ra];
  end

  always_ff @(posedge clk) begin
    if (g2b_we) begin
      g2b_mem[g2b_wa] <= g2b_wd;
    end
    g2b_rd <= g2b_mem[rd2_addr];
  end

  always_ff @(posedge clk) begin
    if (b2g_we) begin
      b2g_mem[b2g_wa] <= b2g_wd;
    end
    b2g_rd <= b2g_mem[rd1_addr];
  end

  // ---------------- second read data, results ----------------
  always_comb begin
    case (s2_dir)
      DIR_B5_TO_GBK: s2_result = (t2s_rd != '0) ? t2s_rd : s2_code;
      DIR_GBK_TO_B5: s2_result = g2b_rd;
      DIR_B5_TO_UNI: s2_result = g2u_rd;
      DIR_GBK_TO_UNI: s2_result = s2_code;
      default: s2_result = s2_code;
    endcase
  end

  always_comb begin
    push_n = 2'd0;
    item0  = '{data: 8'd0, last: 1'b0, eot: 1'b0};
    item1  = '{data: 8'd0, last: 1'b1, eot: 1'b0};
    if (s2_v) begin
      case (s2_kind)
        KIND_PAIR: begin
          push_n = 2'd2;
          item0  = '{data: s2_result[7:0], last: 1'b0, eot: 1'b0};
          item1  = '{data: s2_result[15:8], last: 1'b1, eot: 1'b0};
        end
        KIND_QNUL: begin
          push_n = 2'd2;
          item0  = '{data: QMARK, last: 1'b0, eot: 1'b0};
          item1  = '{data: 8'd0, last: 1'b1, eot: 1'b1};
        end
        KIND_TERM: begin
          if (s2_dir[1]) begin
            push_n = 2'd2;
            item0  = '{data: 8'd0, last: 1'b0, eot: 1'b1};
            item1  = '{data: 8'd0, last: 1'b1, eot: 1'b1};
          end else begin
            push_n = 2'd1;
            item0  = '{data: 8'd0, last: 1'b1, eot: 1'b1};
          end
        end
        KIND_ASCII: begin
          if (s2_dir[1]) begin
            push_n = 2'd2;
            item0  = '{data: s2_byte, last: 1'b0, eot: 1'b0};
            item1  = '{data: 8'd0, last: 1'b1, eot: 1'b0};
          end else begin
            push_n = 2'd1;
            item0  = '{data: s2_byte, last: 1'b1, eot: 1'b0};
          end
        end
        default: push_n = 2'd0;
      endcase
    end
  end

  // ---------------- result queue ----------------
  assign out_valid   = (cnt != '0);
  assign pop         = out_valid && out_ready;
  assign out_byte    = fifo[rp].data;
  assign last        = fifo[rp].last;
  assign end_of_text = fifo[rp].eot;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wp] <= item0;
    end
    if (push_n == 2'd2) begin
      fifo[wp + 1'b1] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + FIFO_AW'(push_n);
      rp  <= rp + FIFO_AW'(pop);
      cnt <= cnt + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  // ---------------- checks ----------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("item taken during table clear");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> !s2_v)
    else $error("two items in the read stages");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_v && s1_kind == KIND_LOAD) |=> !s2_v)
    else $error("load record reached the result stage");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |->
      ((5'(cnt) + 5'(push_n)) <= (5'(FIFO_DEPTH) + 5'(pop))))
    else $error("result queue overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule
